// File: rtl/cinst_pkg.sv
// Package for the case-insensitive name set table.
// Holds sizes, request codes, status codes and the sequencer state type.
// No dependencies.
package cinst_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CHAR_W        = 8;
    localparam int NAME_CHARS    = 15;
    localparam int HEAD_W        = 64;
    localparam int TAIL_W        = 56;
    localparam int NAME_W        = HEAD_W + TAIL_W;
    localparam int WORD_W        = NAME_W + 1;
    localparam int LEN_W         = 6;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 3;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED      = 3'd0,
        STAT_LISTED     = 3'd1,
        STAT_NOT_LISTED = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_BAD_LEN    = 3'd4,
        STAT_REMOVED    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

endpackage

// File: rtl/cinst_fold.sv
// Name normaliser: masks characters beyond the length and folds A-Z to a-z.
// Depends on cinst_pkg.
module cinst_fold (
    input  logic [cinst_pkg::HEAD_W-1:0] name_head,
    input  logic [cinst_pkg::TAIL_W-1:0] name_tail,
    input  logic [cinst_pkg::LEN_W-1:0]  name_length,
    output logic [cinst_pkg::NAME_W-1:0] name_fold
);
    import cinst_pkg::*;

    logic [NAME_W-1:0] name_raw;

    assign name_raw = {name_tail, name_head};

    always_comb begin
        logic [CHAR_W-1:0] c;
        name_fold = '0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            c = name_raw[i*CHAR_W +: CHAR_W];
            if (LEN_W'(i) >= name_length) begin
                c = '0;
            end else if (c inside {[8'h41:8'h5A]}) begin
                c = c + 8'h20;
            end
            name_fold[i*CHAR_W +: CHAR_W] = c;
        end
    end

endmodule

// File: rtl/case_insensitive_name_set_table.sv
// Case-insensitive name set table: top level with slot memory and scan sequencer.
// Depends on cinst_pkg and cinst_fold.
//
// Each request beat is answered by one result beat. After reset the slot memory
// is swept clear, one slot a cycle, through all 1024 slots before the first
// request is taken. A request with a legal length (1 to 15) scans the slots one
// per cycle through the single memory read port: it ends at the first matching
// slot or after the last one, and the result register may then wait on
// m_tready. A length of 0 or above 15 is answered without a scan. Insert writes
// the lowest free slot, remove clears the first match. One request is in flight
// at a time.
module case_insensitive_name_set_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type[1:0], name_head[65:2], name_tail[121:66], name_length[127:122]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], listed[3], zero fill[7:4]
    output logic [7:0]   m_tdata
);
    import cinst_pkg::*;

    logic [WORD_W-1:0] mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0] scan_addr_reg, scan_addr_next;
    logic              issue_done_reg, issue_done_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0] cmp_addr_reg, cmp_addr_next;
    logic              free_found_reg, free_found_next;
    logic [ADDR_W-1:0] free_addr_reg, free_addr_next;
    logic [NAME_W-1:0] name_reg, name_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    status_t           status_reg, status_next;
    logic              listed_reg, listed_next;
    logic              m_tvalid_reg, m_tvalid_next;
    status_t           m_status_reg, m_status_next;
    logic              m_listed_reg, m_listed_next;

    logic [REQ_W-1:0]  in_req;
    logic [LEN_W-1:0]  in_len;
    logic [NAME_W-1:0] name_fold;
    logic              len_ok;
    logic              match;
    logic              slot_free;

    assign in_req = s_tdata[1:0];
    assign in_len = s_tdata[127:122];
    assign len_ok = (in_len != '0) && (in_len <= LEN_W'(NAME_CHARS));

    cinst_fold u_fold (
        .name_head   (s_tdata[65:2]),
        .name_tail   (s_tdata[121:66]),
        .name_length (in_len),
        .name_fold   (name_fold)
    );

    assign match     = (rd_data_reg == {1'b1, name_reg});
    assign slot_free = !rd_data_reg[NAME_W];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        scan_addr_next  = scan_addr_reg;
        issue_done_next = issue_done_reg;
        cmp_valid_next  = 1'b0;
        cmp_addr_next   = cmp_addr_reg;
        free_found_next = free_found_reg;
        free_addr_next  = free_addr_reg;
        name_next       = name_reg;
        req_next        = req_reg;
        status_next     = status_reg;
        listed_next     = listed_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_listed_next   = m_listed_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;
        s_tready        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    name_next       = name_fold;
                    req_next        = in_req;
                    scan_addr_next  = '0;
                    issue_done_next = 1'b0;
                    free_found_next = 1'b0;
                    listed_next     = 1'b0;
                    if (len_ok) begin
                        state_next = S_SCAN;
                    end else begin
                        status_next = (in_req == REQ_INSERT) ? STAT_BAD_LEN : STAT_NOT_LISTED;
                        state_next  = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (!issue_done_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_addr_next  = scan_addr_reg;
                    scan_addr_next = scan_addr_reg + 1'b1;
                    if (scan_addr_reg == LAST_ADDR) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (cmp_valid_reg) begin
                    if (slot_free && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_addr_next  = cmp_addr_reg;
                    end
                    if (match) begin
                        listed_next = 1'b1;
                        state_next  = S_RESP;
                        if (req_reg == REQ_REMOVE) begin
                            mem_we      = 1'b1;
                            mem_waddr   = cmp_addr_reg;
                            status_next = STAT_REMOVED;
                        end else begin
                            status_next = STAT_LISTED;
                        end
                    end else if (cmp_addr_reg == LAST_ADDR) begin
                        listed_next = 1'b0;
                        state_next  = S_RESP;
                        if (req_reg == REQ_INSERT) begin
                            if (free_found_reg || slot_free) begin
                                mem_we      = 1'b1;
                                mem_waddr   = free_found_reg ? free_addr_reg : cmp_addr_reg;
                                mem_wdata   = {1'b1, name_reg};
                                status_next = STAT_ADDED;
                            end else begin
                                status_next = STAT_FULL;
                            end
                        end else begin
                            status_next = STAT_NOT_LISTED;
                        end
                    end
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_listed_next = listed_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            issue_done_reg <= issue_done_next;
            cmp_valid_reg  <= cmp_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg  <= scan_addr_next;
        cmp_addr_reg   <= cmp_addr_next;
        free_found_reg <= free_found_next;
        free_addr_reg  <= free_addr_next;
        name_reg       <= name_next;
        req_reg        <= req_next;
        status_reg     <= status_next;
        listed_reg     <= listed_next;
        m_status_reg   <= m_status_next;
        m_listed_reg   <= m_listed_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_listed_reg, m_status_reg};

    // a beat is taken only once the previous one has been answered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

    // the table is only written by the clearing sweep or at the end of a scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_SCAN))
        else $error("slot write outside clear or scan");

    // listed flag only goes with a found status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |->
            (m_tdata[2:0] == STAT_LISTED || m_tdata[2:0] == STAT_REMOVED))
        else $error("listed flag with wrong status");

    // a removal clears exactly the slot under compare
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && mem_we && req_reg == REQ_REMOVE) |->
            (match && mem_waddr == cmp_addr_reg))
        else $error("removal of a non-matching slot");

endmodule
